[rtl/pltm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pltm_pkg
// Shared types and constants for the parallel link transfer master.
// ----------------------------------------------------------------------------
package pltm_pkg;

  // item opcodes
  localparam logic [2:0] OP_START_WR = 3'd0;
  localparam logic [2:0] OP_START_RD = 3'd1;
  localparam logic [2:0] OP_SPEED    = 3'd2;
  localparam logic [2:0] OP_TICK     = 3'd3;
  localparam logic [2:0] OP_WR_BYTE  = 3'd4;

  // transfer phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_BUSY_XFER  = 3'd1;
  localparam logic [2:0] PH_BUSY_SPEED = 3'd2;
  localparam logic [2:0] PH_WAIT_BYTE  = 3'd3;
  localparam logic [2:0] PH_WGAP       = 3'd4;
  localparam logic [2:0] PH_RGAP       = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_BUSY_POLL = 2'd0;
  localparam logic [1:0] CFG_WR_GAP    = 2'd1;
  localparam logic [1:0] CFG_RD_GAP    = 2'd2;

  localparam logic [5:0] RST_BUSY_POLL = 6'd32;
  localparam logic [5:0] RST_WR_GAP    = 6'd4;
  localparam logic [5:0] RST_RD_GAP    = 6'd32;

  // header bytes
  localparam logic [7:0] HDR_LEN_MASK  = 8'h3f;
  localparam logic [7:0] HDR_READ      = 8'h40;
  localparam logic [7:0] HDR_LONG      = 8'h80;
  localparam logic [7:0] HDR_LO_MASK   = 8'h7f;
  localparam logic [7:0] SPEED_FAST    = 8'hc5;
  localparam logic [7:0] SPEED_SLOW    = 8'hc4;
  localparam logic [13:0] SHORT_MAX    = 14'd64;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [13:0] xfer_size;
    logic        speed_fast;
    logic [7:0]  write_data;
    logic        busy_level;
    logic [7:0]  port_data;
  } in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       bus_drive;
    logic       select_level;
    logic       clock_level;
    logic [7:0] read_data;
    logic       read_valid;
    logic       timed_out;
    logic       refused;
    logic       fast_mode;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [5:0] busy_poll_limit;
    logic [5:0] write_gap;
    logic [5:0] read_gap;
  } cfg_t;

endpackage

[rtl/parallel_link_transfer_master_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_link_transfer_master_core
// Host side of a byte-wide parallel link: headers, busy polling, paced byte
// clocking and select control, one command or tick per beat.
//
//   channel | signals                       | beat
//   --------+-------------------------------+--------------------------------
//   in      | in_valid, in_ready, in_data   | one command, tick or write byte
//   out     | out_valid, out_ready, out_data| one line snapshot per in beat
//   cfg     | cfg_we, cfg_idx, cfg_wdata    | register write, no wait
//
// One beat per cycle while in_ready is high; a result appears the cycle after
// its input beat, set by the single output register.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// in_ready drops only while a result is held and out_ready is low.
// ----------------------------------------------------------------------------
module parallel_link_transfer_master_core
  import pltm_pkg::*;
#(
  parameter int MAX_TRANSFER = 8192
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [5:0] cfg_wdata
);

  cfg_t cfg;
  out_t res;
  logic fire;

  assign fire = in_valid && in_ready;

  pltm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pltm_core #(
    .MAX_TRANSFER (MAX_TRANSFER)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_data),
    .cfg   (cfg),
    .res   (res)
  );

  pltm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .load_data (res),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/pltm_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pltm_cfg
// Configuration register file: busy poll limit and pacing gaps.
// ----------------------------------------------------------------------------
module pltm_cfg
  import pltm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [5:0] cfg_wdata,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_BUSY_POLL: cfg_nxt.busy_poll_limit = cfg_wdata;
        CFG_WR_GAP:    cfg_nxt.write_gap       = cfg_wdata;
        CFG_RD_GAP:    cfg_nxt.read_gap        = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.busy_poll_limit <= RST_BUSY_POLL;
      cfg_r.write_gap       <= RST_WR_GAP;
      cfg_r.read_gap        <= RST_RD_GAP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/pltm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pltm_core
// Link state registers and the per-beat update: header, speed change, busy wait,
// pacing, byte clocking and select release.
// ----------------------------------------------------------------------------
module pltm_core
  import pltm_pkg::*;
#(
  parameter int MAX_TRANSFER = 8192
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  in_t  item,
  input  cfg_t cfg,
  output out_t res
);

  localparam logic [13:0] MAX_SZ = 14'(MAX_TRANSFER);

  logic [2:0]  phase_r, phase_nxt;
  logic        reading_r, reading_nxt;
  logic [13:0] left_r, left_nxt;
  logic [5:0]  poll_r, poll_nxt;
  logic [5:0]  gap_r, gap_nxt;
  logic [7:0]  hdr2_r, hdr2_nxt;
  logic        clk_line_r, clk_line_nxt;
  logic        sel_r, sel_nxt;
  logic [7:0]  bus_r, bus_nxt;
  logic        drive_r, drive_nxt;
  logic        speed_r, speed_nxt;
  logic        pend_r, pend_nxt;

  logic [13:0] n;
  logic        wait_done;

  assign n = item.xfer_size - 14'd1;

  always_comb begin
    phase_nxt    = phase_r;
    reading_nxt  = reading_r;
    left_nxt     = left_r;
    poll_nxt     = poll_r;
    gap_nxt      = gap_r;
    hdr2_nxt     = hdr2_r;
    clk_line_nxt = clk_line_r;
    sel_nxt      = sel_r;
    bus_nxt      = bus_r;
    drive_nxt    = drive_r;
    speed_nxt    = speed_r;
    pend_nxt     = pend_r;
    wait_done    = 1'b0;
    res          = '0;

    case (item.opcode)
      OP_START_WR, OP_START_RD, OP_SPEED: begin
        if (phase_r != PH_IDLE || (item.opcode != OP_SPEED &&
            (item.xfer_size == 14'd0 || item.xfer_size > MAX_SZ))) begin
          res.refused = 1'b1;
        end else begin
          if (item.opcode == OP_SPEED) begin
            bus_nxt   = item.speed_fast ? SPEED_FAST : SPEED_SLOW;
            pend_nxt  = item.speed_fast;
            phase_nxt = PH_BUSY_SPEED;
          end else begin
            reading_nxt = (item.opcode == OP_START_RD);
            left_nxt    = item.xfer_size;
            if (item.xfer_size <= SHORT_MAX) begin
              bus_nxt  = (reading_nxt ? HDR_READ : 8'h00) | (n[7:0] & HDR_LEN_MASK);
              hdr2_nxt = 8'h00;
            end else begin
              bus_nxt  = HDR_LONG | ({1'b0, n[13:7]} & HDR_LEN_MASK);
              hdr2_nxt = (reading_nxt ? HDR_LONG : 8'h00) | (n[7:0] & HDR_LO_MASK);
            end
            phase_nxt = PH_BUSY_XFER;
          end
          sel_nxt  = 1'b0;
          poll_nxt = cfg.busy_poll_limit;
          if (cfg.busy_poll_limit == 6'd0) begin
            res.timed_out = 1'b1;
            wait_done     = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (phase_r == PH_BUSY_XFER || phase_r == PH_BUSY_SPEED) begin
          if (!item.busy_level) begin
            wait_done = 1'b1;
          end else begin
            poll_nxt = poll_r - 6'd1;
            if (poll_nxt == 6'd0) begin
              wait_done     = 1'b1;
              res.timed_out = 1'b1;
            end
          end
        end else if (phase_r == PH_WGAP) begin
          gap_nxt = gap_r - 6'd1;
          if (gap_nxt == 6'd0) begin
            if (left_r == 14'd0) begin
              sel_nxt   = 1'b1;
              drive_nxt = 1'b1;
              phase_nxt = PH_IDLE;
              res.last  = 1'b1;
            end else begin
              phase_nxt = PH_WAIT_BYTE;
            end
          end
        end else if (phase_r == PH_RGAP) begin
          if (gap_r != 6'd0) begin
            gap_nxt = gap_r - 6'd1;
          end else begin
            clk_line_nxt   = ~clk_line_r;
            res.read_data  = item.port_data;
            res.read_valid = 1'b1;
            left_nxt       = left_r - 14'd1;
            if (left_nxt == 14'd0) begin
              sel_nxt   = 1'b1;
              drive_nxt = 1'b1;
              phase_nxt = PH_IDLE;
              res.last  = 1'b1;
            end else begin
              gap_nxt = cfg.read_gap;
            end
          end
        end
      end
      OP_WR_BYTE: begin
        if (phase_r == PH_WAIT_BYTE) begin
          bus_nxt      = item.write_data;
          clk_line_nxt = ~clk_line_r;
          left_nxt     = left_r - 14'd1;
          gap_nxt      = cfg.write_gap;
          if (cfg.write_gap != 6'd0) begin
            phase_nxt = PH_WGAP;
          end else if (left_nxt == 14'd0) begin
            sel_nxt   = 1'b1;
            drive_nxt = 1'b1;
            phase_nxt = PH_IDLE;
            res.last  = 1'b1;
          end
        end else begin
          res.refused = 1'b1;
        end
      end
      default: res.refused = 1'b1;
    endcase

    // busy wait finished: speed change closes, transfers move to data
    if (wait_done) begin
      if (phase_nxt == PH_BUSY_SPEED) begin
        sel_nxt   = 1'b1;
        speed_nxt = pend_nxt;
        phase_nxt = PH_IDLE;
        res.last  = 1'b1;
      end else begin
        if (left_nxt > SHORT_MAX) begin
          bus_nxt      = hdr2_nxt;
          clk_line_nxt = ~clk_line_nxt;
        end
        if (reading_nxt) begin
          drive_nxt = 1'b0;
          gap_nxt   = cfg.read_gap;
          phase_nxt = PH_RGAP;
        end else begin
          phase_nxt = PH_WAIT_BYTE;
        end
      end
    end

    res.data_out     = bus_nxt;
    res.bus_drive    = drive_nxt;
    res.select_level = sel_nxt;
    res.clock_level  = clk_line_nxt;
    res.fast_mode    = speed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      reading_r  <= 1'b0;
      left_r     <= '0;
      poll_r     <= '0;
      gap_r      <= '0;
      hdr2_r     <= '0;
      clk_line_r <= 1'b1;
      sel_r      <= 1'b1;
      bus_r      <= 8'hff;
      drive_r    <= 1'b1;
      speed_r    <= 1'b0;
      pend_r     <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      reading_r  <= reading_nxt;
      left_r     <= left_nxt;
      poll_r     <= poll_nxt;
      gap_r      <= gap_nxt;
      hdr2_r     <= hdr2_nxt;
      clk_line_r <= clk_line_nxt;
      sel_r      <= sel_nxt;
      bus_r      <= bus_nxt;
      drive_r    <= drive_nxt;
      speed_r    <= speed_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

[rtl/pltm_obuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pltm_obuf
// Result register with valid/ready; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module pltm_obuf
  import pltm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  out_t load_data,
  output logic can_load,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic valid_r, valid_nxt;
  out_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
